// ===== rtl/aosmp_pkg.sv =====
// ----------------------------------------------------------------------------
// aosmp_pkg
// Types and constants for the AOS M_PDU packer: request formats, the
// parser-to-zone queue entry, and the packet and zone constants.
// ----------------------------------------------------------------------------
package aosmp_pkg;

  // request kinds
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_FILL = 1'b1;

  localparam logic [7:0]  MARK_HI    = 8'hEA;
  localparam logic [7:0]  MARK_LO    = 8'h00;
  localparam logic [7:0]  IDLE_BYTE  = 8'hE0;
  localparam logic [10:0] NO_HDR     = 11'h7FF;
  localparam logic [15:0] MIN_PKT    = 16'd4;
  localparam logic [10:0] ZONE_MIN   = 11'd8;
  localparam logic [10:0] ZONE_MAX   = 11'd2046;
  localparam logic [10:0] ZONE_RESET = 11'd1024;

  // header byte positions within a packet
  localparam logic [15:0] POS_MARK_HI = 16'd0;
  localparam logic [15:0] POS_MARK_LO = 16'd1;
  localparam logic [15:0] POS_LEN_HI  = 16'd2;
  localparam logic [15:0] POS_LEN_LO  = 16'd3;

  // parser-to-zone queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // output buffer
  localparam int ODEPTH = 2;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        zone_last;
    logic [10:0] first_hdr_ptr;
    logic        hdr_error;
  } out_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_start;
    logic       hdr_error;
  } mid_t;

endpackage

// ===== rtl/aos_mpdu_packer.sv =====
// ----------------------------------------------------------------------------
// aos_mpdu_packer
// Cuts a packet byte stream into fixed-size M_PDU data zones and reports
// the first header pointer of each zone with its last byte.
// ----------------------------------------------------------------------------
//  channel   ports                     request accepted when
//  input     push, full, req           push & !full
//  result    empty, pop, rsp           pop & !empty
//  config    cfg_we, cfg_data          cfg_we
//
// One byte per cycle sustained while results are popped; a byte is registered
// in the queue by the parser and in the output buffer by the zone stage.
// Parser and zone stage are joined by a four-entry queue; a held result only
// stalls input once that queue and the two-entry output buffer are full.
// Synchronous reset clears all counters and sets the zone length to 1024.
// ----------------------------------------------------------------------------
module aos_mpdu_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  aosmp_pkg::in_req_t  req,
  output logic                empty,
  input  logic                pop,
  output aosmp_pkg::out_req_t rsp,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data
);

  aosmp_pkg::mid_t mid_in;
  aosmp_pkg::mid_t mid_out;
  logic            accept;
  logic            mid_empty;
  logic            mid_pop;

  assign accept = push && !full;

  aosmp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .mid    (mid_in)
  );

  aosmp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (mid_in),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (mid_out),
    .empty   (mid_empty)
  );

  aosmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mid       (mid_out),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .rsp       (rsp),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== rtl/aosmp_front.sv =====
// ----------------------------------------------------------------------------
// aosmp_front
// Packet parser: checks the marker, reads the length and tracks packet
// boundaries; tags each byte with packet start and header error, and turns fill requests into idle bytes.
// ----------------------------------------------------------------------------
module aosmp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  aosmp_pkg::in_req_t req,
  output aosmp_pkg::mid_t   mid
);

  logic [15:0] pkt_count;
  logic [15:0] pkt_count_next;
  logic [15:0] pkt_len;
  logic [15:0] pkt_len_next;
  logic [7:0]  len_high;
  logic [7:0]  len_high_next;
  logic [15:0] len_word;
  logic [15:0] count_inc;

  always_comb begin
    pkt_count_next = pkt_count;
    pkt_len_next   = pkt_len;
    len_high_next  = len_high;
    len_word       = {len_high, req.in_byte};
    count_inc      = pkt_count + 16'd1;
    mid.data       = req.in_byte;
    mid.pkt_start  = 1'b0;
    mid.hdr_error  = 1'b0;
    if (req.req_type == aosmp_pkg::REQ_FILL) begin
      mid.data = aosmp_pkg::IDLE_BYTE;
    end else begin
      priority if (pkt_count == aosmp_pkg::POS_MARK_HI) begin
        mid.pkt_start = 1'b1;
        pkt_len_next  = 16'd0;
        if (req.in_byte != aosmp_pkg::MARK_HI) begin
          mid.hdr_error = 1'b1;
          pkt_len_next  = 16'd1;
        end
      end else if (pkt_count == aosmp_pkg::POS_MARK_LO) begin
        if (req.in_byte != aosmp_pkg::MARK_LO) begin
          mid.hdr_error = 1'b1;
          pkt_len_next  = 16'd1;
        end
      end else if (pkt_count == aosmp_pkg::POS_LEN_HI) begin
        len_high_next = req.in_byte;
      end else if (pkt_count == aosmp_pkg::POS_LEN_LO) begin
        pkt_len_next = len_word;
        if (len_word < aosmp_pkg::MIN_PKT) begin
          mid.hdr_error = 1'b1;
          pkt_len_next  = aosmp_pkg::MIN_PKT;
        end
        // bad marker earlier in the header forces the minimum length
        if (pkt_len[0]) begin
          pkt_len_next = aosmp_pkg::MIN_PKT;
        end
      end else begin
        pkt_len_next = pkt_len;
      end
      pkt_count_next = count_inc;
      if (count_inc >= aosmp_pkg::MIN_PKT && count_inc >= pkt_len_next) begin
        pkt_count_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_count <= 16'd0;
      pkt_len   <= 16'd0;
      len_high  <= 8'd0;
    end else if (accept) begin
      pkt_count <= pkt_count_next;
      pkt_len   <= pkt_len_next;
      len_high  <= len_high_next;
    end
  end

endmodule

// ===== rtl/aosmp_queue.sv =====
// ----------------------------------------------------------------------------
// aosmp_queue
// Short queue between the packet parser and the zone stage.
// ----------------------------------------------------------------------------
module aosmp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  aosmp_pkg::mid_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output aosmp_pkg::mid_t rd_data,
  output logic            empty
);

  aosmp_pkg::mid_t entries [aosmp_pkg::QDEPTH];

  logic [aosmp_pkg::QPTR_W-1:0] wptr;
  logic [aosmp_pkg::QPTR_W-1:0] rptr;
  logic [aosmp_pkg::QCNT_W-1:0] count;

  assign full    = (count == aosmp_pkg::QCNT_W'(aosmp_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/aosmp_back.sv =====
// ----------------------------------------------------------------------------
// aosmp_back
// Zone stage: places bytes in the data zone, records the first packet
// start, marks the last byte, and buffers results for the consumer.
// ----------------------------------------------------------------------------
module aosmp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data,
  input  aosmp_pkg::mid_t     mid,
  input  logic                mid_empty,
  output logic                mid_pop,
  output aosmp_pkg::out_req_t rsp,
  output logic                empty,
  input  logic                pop
);

  logic [10:0] zone_length;
  logic [10:0] zone_pos;
  logic [10:0] zone_first_hdr;
  logic [10:0] zlen;
  logic [10:0] hdr_cur;
  logic        last;
  logic        out_pop;
  logic        out_room;

  aosmp_pkg::out_req_t result;
  aosmp_pkg::out_req_t obuf [aosmp_pkg::ODEPTH];

  logic [aosmp_pkg::OPTR_W-1:0] owptr;
  logic [aosmp_pkg::OPTR_W-1:0] orptr;
  logic [aosmp_pkg::OCNT_W-1:0] ocount;

  assign empty    = (ocount == '0);
  assign out_pop  = pop && !empty;
  assign out_room = (ocount != aosmp_pkg::OCNT_W'(aosmp_pkg::ODEPTH)) || out_pop;
  assign mid_pop  = !mid_empty && out_room;
  assign rsp      = obuf[orptr];

  always_comb begin
    zlen = zone_length;
    if (zone_length < aosmp_pkg::ZONE_MIN) begin
      zlen = aosmp_pkg::ZONE_MIN;
    end else if (zone_length > aosmp_pkg::ZONE_MAX) begin
      zlen = aosmp_pkg::ZONE_MAX;
    end
    last    = ({1'b0, zone_pos} + 12'd1) >= {1'b0, zlen};
    hdr_cur = (mid.pkt_start && zone_first_hdr == aosmp_pkg::NO_HDR) ? zone_pos
                                                                      : zone_first_hdr;
    result.out_byte      = mid.data;
    result.zone_last     = last;
    result.first_hdr_ptr = last ? hdr_cur : 11'd0;
    result.hdr_error     = mid.hdr_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_length <= aosmp_pkg::ZONE_RESET;
    end else if (cfg_we) begin
      zone_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_pos       <= 11'd0;
      zone_first_hdr <= aosmp_pkg::NO_HDR;
    end else if (mid_pop) begin
      if (last) begin
        zone_pos       <= 11'd0;
        zone_first_hdr <= aosmp_pkg::NO_HDR;
      end else begin
        zone_pos       <= zone_pos + 11'd1;
        zone_first_hdr <= hdr_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      obuf[owptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
    end else begin
      if (mid_pop) begin
        owptr <= owptr + 1'b1;
      end
      if (out_pop) begin
        orptr <= orptr + 1'b1;
      end
      unique case ({mid_pop, out_pop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

endmodule
